// File: rtl/core/datagram_reorder_buffer_top_assert.svh
// assertion macros shared by the reorder buffer modules
`ifndef DATAGRAM_REORDER_BUFFER_TOP_ASSERT_SVH
`define DATAGRAM_REORDER_BUFFER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define DRB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define DRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/drb_pkg.sv
// shared constants and controller/datapath interface types of the reorder buffer
`default_nettype none

package drb_pkg;

    localparam int WINDOW_DEF = 64;
    localparam int SEQ_W      = 16;
    localparam int PAY_W      = 32;
    localparam int BATCH_W    = 16;
    localparam int TDATA_W    = SEQ_W + PAY_W;

    localparam logic [BATCH_W-1:0] BATCH_RST = BATCH_W'(1);

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear_step;
        logic in_load;
        logic insert;
        logic read_head;
        logic take;
        logic emit_drop;
        logic emit_mid;
        logic emit_last;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clear_done;
        logic in_window;
        logic batch_done;
        logic head_valid;
        logic hold_full;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/core/datagram_reorder_buffer_top.sv
// Reorder buffer top level: datagrams are placed by sequence number and released in order.
// An in-window beat is written to the slot memories in the cycle after it is taken; a drop beat
// passes the input register and then the output register, and waits while that one is held.
// A new input beat is taken only once the last one is done; a release walks the slots in turn
// through the registered read of the slot memories and stalls input until the run ends.
// Reset: synchronous active-low; then a clearing pass over every slot of the valid store.
`default_nettype none

module datagram_reorder_buffer_top #(
    parameter int WINDOW = drb_pkg::WINDOW_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration: batch_size
    input  wire logic                        cfg_we,
    input  wire logic [drb_pkg::BATCH_W-1:0] cfg_wdata,
    // input channel
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [drb_pkg::TDATA_W-1:0] s_tdata,   // seq_number[15:0], payload[47:16]
    // result channel
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [drb_pkg::TDATA_W-1:0]      m_tdata,   // out_seq[15:0], out_payload[47:16]
    output logic                             m_tlast,   // run_last
    output logic                             m_tuser    // dropped
);

    drb_pkg::cmd_t    cmd;
    drb_pkg::status_t status;

    drb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    drb_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// File: rtl/core/drb_datapath.sv
// reorder buffer datapath: slot memories, sequence tracking, hold and output registers
`default_nettype none

module drb_datapath #(
    parameter int WINDOW = drb_pkg::WINDOW_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic [drb_pkg::BATCH_W-1:0] cfg_wdata,
    input  wire logic [drb_pkg::TDATA_W-1:0] s_tdata,
    input  wire drb_pkg::cmd_t               cmd,
    output drb_pkg::status_t                 status,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [drb_pkg::TDATA_W-1:0]      m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser
);

    localparam int SEQ_W   = drb_pkg::SEQ_W;
    localparam int PAY_W   = drb_pkg::PAY_W;
    localparam int BATCH_W = drb_pkg::BATCH_W;
    localparam int SLOT_W  = $clog2(WINDOW);

    localparam logic [SLOT_W:0]   WIN_EXT   = (SLOT_W + 1)'(WINDOW);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    localparam logic [SEQ_W-1:0]  WIN_SEQ   = SEQ_W'(WINDOW);
    localparam logic [SEQ_W-1:0]  SEQ_LAST  = '1;

    // slot memories
    logic [PAY_W-1:0] pay_mem [WINDOW];
    logic             vld_mem [WINDOW];

    logic [BATCH_W-1:0] batch_reg, batch_next;
    logic [BATCH_W-1:0] cnt_reg, cnt_next;
    logic [SEQ_W-1:0]   expected_reg, expected_next;
    logic [SLOT_W-1:0]  head_reg, head_next;
    logic [SLOT_W-1:0]  clr_reg, clr_next;
    logic               hold_valid_reg, hold_valid_next;
    logic               m_valid_reg, m_valid_next;

    logic [SEQ_W-1:0]   in_seq_reg;
    logic [PAY_W-1:0]   in_pay_reg;
    logic               rd_valid_reg;
    logic [PAY_W-1:0]   rd_pay_reg;
    logic [SEQ_W-1:0]   hold_seq_reg;
    logic [PAY_W-1:0]   hold_pay_reg;
    logic [SEQ_W-1:0]   m_seq_reg;
    logic [PAY_W-1:0]   m_pay_reg;
    logic               m_last_reg;
    logic               m_drop_reg;

    logic [SEQ_W-1:0]   seq_dist;
    logic               in_window;
    logic               wrapped;
    logic [SLOT_W:0]    slot_sum;
    logic [SLOT_W-1:0]  ins_slot;
    logic [BATCH_W-1:0] cnt_inc;
    logic               batch_done;
    logic               out_free;
    logic               vld_we;
    logic [SLOT_W-1:0]  vld_addr;
    logic               vld_wd;

    // window test and slot of the held arrival
    always_comb begin
        seq_dist  = in_seq_reg - expected_reg;
        in_window = seq_dist < WIN_SEQ;
        wrapped   = in_seq_reg < expected_reg;
        slot_sum  = {1'b0, head_reg} + {1'b0, seq_dist[SLOT_W-1:0]};
        if (wrapped) begin
            // seq passed the 16-bit wrap, so it is below the window size
            ins_slot = in_seq_reg[SLOT_W-1:0];
        end else if (slot_sum >= WIN_EXT) begin
            ins_slot = SLOT_W'(slot_sum - WIN_EXT);
        end else begin
            ins_slot = slot_sum[SLOT_W-1:0];
        end
    end

    // batch counter compare
    assign cnt_inc    = cnt_reg + BATCH_W'(1);
    assign batch_done = !(cnt_inc < batch_reg);
    assign out_free   = !m_valid_reg || m_tready;

    // valid store write port: clearing pass, insert, or release
    always_comb begin
        vld_we   = cmd.clear_step || cmd.insert || cmd.take;
        vld_addr = head_reg;
        vld_wd   = 1'b0;
        if (cmd.clear_step) begin
            vld_addr = clr_reg;
        end else if (cmd.insert) begin
            vld_addr = ins_slot;
            vld_wd   = 1'b1;
        end
    end

    // valid store
    always_ff @(posedge aclk) begin
        if (vld_we) begin
            vld_mem[vld_addr] <= vld_wd;
        end
        if (cmd.read_head) begin
            rd_valid_reg <= vld_mem[head_reg];
        end
    end

    // payload store
    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            pay_mem[ins_slot] <= in_pay_reg;
        end
        if (cmd.read_head) begin
            rd_pay_reg <= pay_mem[head_reg];
        end
    end

    // next state of control registers
    always_comb begin
        batch_next      = cfg_we ? cfg_wdata : batch_reg;
        cnt_next        = cnt_reg;
        expected_next   = expected_reg;
        head_next       = head_reg;
        clr_next        = clr_reg;
        hold_valid_next = hold_valid_reg;
        m_valid_next    = m_valid_reg;

        if (cmd.clear_step) begin
            clr_next = clr_reg + SLOT_W'(1);
        end
        if (cmd.insert) begin
            cnt_next = batch_done ? '0 : cnt_inc;
        end
        if (cmd.take) begin
            expected_next = expected_reg + SEQ_W'(1);
            if (expected_reg == SEQ_LAST || head_reg == SLOT_LAST) begin
                head_next = '0;
            end else begin
                head_next = head_reg + SLOT_W'(1);
            end
        end
        if (cmd.emit_mid || cmd.emit_last) begin
            hold_valid_next = 1'b0;
        end
        if (cmd.take) begin
            hold_valid_next = 1'b1;
        end
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit_drop || cmd.emit_mid || cmd.emit_last) begin
            m_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batch_reg      <= drb_pkg::BATCH_RST;
            cnt_reg        <= '0;
            expected_reg   <= '0;
            head_reg       <= '0;
            clr_reg        <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            batch_reg      <= batch_next;
            cnt_reg        <= cnt_next;
            expected_reg   <= expected_next;
            head_reg       <= head_next;
            clr_reg        <= clr_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // input, hold and output payload registers
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            in_seq_reg <= s_tdata[SEQ_W-1:0];
            in_pay_reg <= s_tdata[SEQ_W +: PAY_W];
        end
        if (cmd.take) begin
            hold_seq_reg <= expected_reg;
            hold_pay_reg <= rd_pay_reg;
        end
        if (cmd.emit_drop) begin
            m_seq_reg  <= in_seq_reg;
            m_pay_reg  <= '0;
            m_last_reg <= 1'b0;
            m_drop_reg <= 1'b1;
        end else if (cmd.emit_mid || cmd.emit_last) begin
            m_seq_reg  <= hold_seq_reg;
            m_pay_reg  <= hold_pay_reg;
            m_last_reg <= cmd.emit_last;
            m_drop_reg <= 1'b0;
        end
    end

    // status and output port
    always_comb begin
        status.clear_done = clr_reg == SLOT_LAST;
        status.in_window  = in_window;
        status.batch_done = batch_done;
        status.head_valid = rd_valid_reg;
        status.hold_full  = hold_valid_reg;
        status.out_free   = out_free;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pay_reg, m_seq_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_drop_reg;

    `include "datagram_reorder_buffer_top_assert.svh"

    `DRB_ASSERT_NEXT(a_take_advances, aclk, aresetn, cmd.take,
        expected_reg == SEQ_W'($past(expected_reg) + SEQ_W'(1)),
        "expected sequence did not advance on release")
    `DRB_ASSERT_NOW(a_head_in_range, aclk, aresetn, 1'b1, head_reg <= SLOT_LAST,
        "head slot beyond window")
    `DRB_ASSERT_NEXT(a_drop_beat, aclk, aresetn, cmd.emit_drop,
        m_tvalid && m_tuser && !m_tlast, "drop beat not presented")

endmodule

`default_nettype wire

// File: rtl/core/drb_ctrl.sv
// reorder buffer controller: clearing pass, insert/drop decision and release walk
`default_nettype none

module drb_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire drb_pkg::status_t status,
    output drb_pkg::cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EVAL  = 5'b00100,
        ST_READ  = 5'b01000,
        ST_CHECK = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.in_load = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!status.in_window) begin
                    if (status.out_free) begin
                        cmd.emit_drop = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    cmd.insert = 1'b1;
                    state_next = status.batch_done ? ST_READ : ST_IDLE;
                end
            end
            ST_READ: begin
                cmd.read_head = 1'b1;
                state_next    = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.head_valid) begin
                    if (!status.hold_full) begin
                        cmd.take   = 1'b1;
                        state_next = ST_READ;
                    end else if (status.out_free) begin
                        cmd.emit_mid = 1'b1;
                        cmd.take     = 1'b1;
                        state_next   = ST_READ;
                    end
                end else if (status.hold_full) begin
                    if (status.out_free) begin
                        cmd.emit_last = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    `include "datagram_reorder_buffer_top_assert.svh"

    `DRB_ASSERT_NOW(a_emit_needs_room, aclk, aresetn, cmd.emit_drop || cmd.emit_mid || cmd.emit_last, status.out_free, "beat loaded while output register busy")
    `DRB_ASSERT_NOW(a_take_needs_valid, aclk, aresetn, cmd.take, status.head_valid && state_reg == ST_CHECK, "release of an empty slot")
    `DRB_ASSERT_NOW(a_insert_in_window, aclk, aresetn, cmd.insert, status.in_window && !cmd.emit_drop, "insert of a number outside the window")

endmodule

`default_nettype wire

// File: tb/sv/datagram_reorder_buffer_top_tb.sv
// self-checking testbench for the datagram reorder buffer top level
`timescale 1ns / 100ps

module datagram_reorder_buffer_top_tb;

    localparam int WIN    = drb_pkg::WINDOW_DEF;
    localparam int LIMIT  = 400000;
    localparam int SETTLE = 16;
    localparam int HOLD   = 400;

    typedef struct packed {
        logic [15:0] seq;
        logic [31:0] pay;
        logic        last;
        logic        drop;
    } dgram_res_t;

    logic                        aclk;
    logic                        aresetn   = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [drb_pkg::BATCH_W-1:0] cfg_wdata = '0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [drb_pkg::TDATA_W-1:0] s_tdata   = '0;    // seq_number[15:0], payload[47:16]
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [drb_pkg::TDATA_W-1:0] m_tdata;           // out_seq[15:0], out_payload[47:16]
    logic                        m_tlast;           // run_last
    logic                        m_tuser;           // dropped

    // pending input beats and results still owed by the block
    logic [drb_pkg::TDATA_W-1:0] dgram_q [$];
    dgram_res_t                  out_due_q [$];

    // shadow of the reorder state
    logic [31:0] slot_pay [WIN];
    bit          slot_full [WIN];
    logic [15:0] run_head  = '0;
    logic [15:0] arrivals  = '0;
    logic [15:0] batch_len = 16'd1;

    int idle_pct  = 30;
    bit hold_arm  = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int bad_cnt   = 0;
    int cyc       = 0;

    datagram_reorder_buffer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // place one accepted datagram and queue whatever it releases or drops
    function automatic void place_datagram(input logic [15:0] seq, input logic [31:0] pay);
        logic [15:0] seq_dist;
        dgram_res_t  res;
        int          n;
        int          head;
        seq_dist = seq - run_head;
        if (seq_dist >= 16'(WIN)) begin
            res = '{seq: seq, pay: 32'd0, last: 1'b0, drop: 1'b1};
            out_due_q.push_back(res);
            return;
        end
        slot_pay[int'(seq) % WIN]  = pay;
        slot_full[int'(seq) % WIN] = 1'b1;
        arrivals = arrivals + 16'd1;
        if (arrivals < batch_len)
            return;
        arrivals = '0;
        // walk the unbroken run from the head, at most one window long
        n    = 0;
        head = int'(run_head) % WIN;
        while (n < WIN && slot_full[head]) begin
            slot_full[head] = 1'b0;
            res.seq  = run_head;
            res.pay  = slot_pay[head];
            res.drop = 1'b0;
            res.last = (n == WIN - 1) || !slot_full[(head + 1) % WIN];
            out_due_q.push_back(res);
            run_head = run_head + 16'd1;
            head     = int'(run_head) % WIN;
            n++;
        end
    endfunction

    task automatic push_item(input logic [15:0] seq, input logic [31:0] pay);
        dgram_q.push_back({pay, seq});
    endtask

    // shuffled run of consecutive numbers, optionally with one hole, plus stray beats
    task automatic push_round(input logic [15:0] base, input int n, input bit gap);
        logic [15:0] ord [$];
        logic [15:0] tmp;
        int          j;
        int          skip;
        for (int i = 0; i < n; i++)
            ord.push_back(base + 16'(i));
        for (int i = n - 1; i > 0; i--) begin
            j      = $urandom_range(i);
            tmp    = ord[i];
            ord[i] = ord[j];
            ord[j] = tmp;
        end
        skip = gap ? int'($urandom_range(n - 1)) : -1;
        foreach (ord[i]) begin
            if (i != skip) begin
                push_item(ord[i], $urandom);
                if ($urandom_range(99) < 5)
                    push_item(ord[i], $urandom);
            end
            if ($urandom_range(99) < 8)
                push_item(16'($urandom), $urandom);
        end
    endtask

    // rounds that start at the current head once the previous one is taken
    task automatic run_rounds(input int quota, input bit gaps);
        int sent;
        int n;
        sent = 0;
        while (sent < quota) begin
            while (dgram_q.size() != 0) @(posedge aclk);
            n = $urandom_range(2, 12);
            push_round(run_head, n, gaps && ($urandom_range(2) == 0));
            sent += n;
        end
    endtask

    // write batch_size once the block has gone quiet
    task automatic set_batch(input logic [15:0] val);
        while (dgram_q.size() != 0 || out_due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        batch_len = val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // input driver: offers the oldest pending beat, predicts on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                place_datagram(s_tdata[15:0], s_tdata[47:16]);
                void'(dgram_q.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (dgram_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= dgram_q[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // result monitor: each beat against the oldest owed result
    always @(posedge aclk) begin
        dgram_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (out_due_q.size() == 0) begin
                if (bad_cnt < 10)
                    $display("cycle %0d: unexpected beat seq %h pay %h last %b drop %b",
                             cyc, m_tdata[15:0], m_tdata[47:16], m_tlast, m_tuser);
                bad_cnt++;
            end else begin
                want = out_due_q.pop_front();
                if (m_tdata[15:0] !== want.seq || m_tdata[47:16] !== want.pay ||
                    m_tlast !== want.last || m_tuser !== want.drop) begin
                    if (bad_cnt < 10)
                        $display({"cycle %0d: seq %h/%h pay %h/%h last %b/%b drop %b/%b",
                                  " (expected/actual)"}, cyc, want.seq, m_tdata[15:0],
                                 want.pay, m_tdata[47:16], want.last, m_tlast,
                                 want.drop, m_tuser);
                    bad_cnt++;
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT) begin
            $display("[datagram_reorder_buffer_top] ERROR");
            $finish;
        end
    end

    initial begin
        logic [15:0] base;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // in-order head, hole then fill, overwrite, stale and out-of-window numbers
        set_batch(16'd1);
        push_item(16'd0,     32'h0000_0000);
        push_item(16'd2,     32'hFFFF_FFFF);
        push_item(16'd2,     32'hA5A5_A5A5);
        push_item(16'd1,     32'h5A5A_5A5A);
        push_item(16'd0,     32'h1234_5678);
        push_item(16'hFFFF,  32'hFFFF_FFFF);
        push_item(16'd66,    32'h0F0F_F0F0);
        push_item(16'd67,    32'h8000_0001);
        push_item(16'd3,     32'h0000_0000);
        push_item(16'h8000,  32'h7FFF_FFFF);
        push_item(16'h5555,  32'hAAAA_AAAA);
        push_item(16'hAAAA,  32'h5555_5555);

        // zero batch size behaves as one
        set_batch(16'd0);
        push_item(16'd5, 32'h0000_0001);
        push_item(16'd4, 32'h0000_0002);

        // largest batch: fill the window behind an empty head, nothing is released
        set_batch(16'hFFFF);
        base = run_head;
        push_round(base + 16'd1, WIN - 1, 1'b0);

        // the head beat frees a full-window run while the receiver holds off
        set_batch(16'd1);
        idle_pct = 0;
        hold_arm = 1'b1;
        push_item(base, $urandom);
        push_round(base + 16'(WIN), 6, 1'b0);
        run_rounds(1, 1'b0);
        idle_pct = 30;

        set_batch(16'd3);
        run_rounds(6, 1'b1);

        set_batch(16'($urandom_range(2, 8)));
        run_rounds(6, 1'b1);

        // drain and let the block settle
        while (dgram_q.size() != 0 || out_due_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (bad_cnt == 0)
            $display("[datagram_reorder_buffer_top] OK");
        else
            $display("[datagram_reorder_buffer_top] ERROR");
        $finish;
    end

endmodule
